// File: rtl/vta_pkg.sv
// shared widths, register indexes, reset values and op codes for the
// velocity thrust allocator; no dependencies
package vta_pkg;

  localparam int unsigned SpeedW = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned IntegW = 32;
  localparam int unsigned SurfW  = 40;
  localparam int unsigned DriveW = 36;
  localparam int unsigned AllocW = DriveW + 1;
  localparam int unsigned GainW  = 24;
  localparam int unsigned TickW  = 16;
  localparam int unsigned ForceW = 24;
  localparam int unsigned NumThr = 4;

  // shared multiplier: signed a times unsigned b, a split in two halves
  localparam int unsigned MacAW    = 48;
  localparam int unsigned MacBW    = 24;
  localparam int unsigned MacHalfW = MacAW / 2;
  localparam int unsigned MacPW    = MacAW + MacBW;

  // shared square root / divide unit
  localparam int unsigned RdNumW    = 61;
  localparam int unsigned RdDenW    = AllocW;
  localparam int unsigned RdResW    = 28;
  localparam int unsigned RdRootInW = 2 * RdResW;
  localparam int unsigned RdCntW    = 5;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSurgeRoot   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSurgeLinear = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSurgeWeight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSwayRoot    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSwayLinear  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSwayWeight  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxThrust   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgTickPeriod  = 3'd7;

  localparam logic [GainW-1:0] RootGainRst  = 24'd6554;
  localparam logic [GainW-1:0] LinGainRst   = 24'd66;
  localparam logic [GainW-1:0] WeightRst    = 24'd66;
  localparam logic [GainW-1:0] MaxThrustRst = 24'd26214;
  localparam logic [TickW-1:0] TickRst      = 16'd1311;

  // sqrt(2)/4 in Q0.16
  localparam logic [MacBW-1:0] AllocK = 24'd23170;

  typedef enum logic {
    RD_ROOT,
    RD_DIV
  } rd_op_e;

endpackage

// File: rtl/vta_mac.sv
// shared multiplier: signed 48 bit by unsigned 24 bit in two passes of one
// 25x25 multiplier; uses vta_pkg
module vta_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [vta_pkg::MacAW-1:0] a_i,
  input  logic        [vta_pkg::MacBW-1:0] b_i,
  output logic                             done_o,
  output logic signed [vta_pkg::MacPW-1:0] prod_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_DONE
  } mac_state_e;

  mac_state_e                       state_q;
  logic signed [vta_pkg::MacAW-1:0] a_q;
  logic        [vta_pkg::MacBW-1:0] b_q;
  logic signed [vta_pkg::MacPW-1:0] acc_q;

  logic signed [vta_pkg::MacHalfW:0]     mul_a;
  logic signed [vta_pkg::MacBW:0]        mul_b;
  logic signed [vta_pkg::MacHalfW+vta_pkg::MacBW+1:0] mul_p;

  always_comb begin
    if (state_q == M_LO) begin
      mul_a = $signed({1'b0, a_q[vta_pkg::MacHalfW-1:0]});
    end else begin
      mul_a = $signed({a_q[vta_pkg::MacAW-1], a_q[vta_pkg::MacAW-1:vta_pkg::MacHalfW]});
    end
    mul_b = $signed({1'b0, b_q});
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            state_q <= M_LO;
          end
        end
        M_LO: begin
          acc_q   <= vta_pkg::MacPW'(mul_p);
          state_q <= M_HI;
        end
        M_HI: begin
          acc_q   <= acc_q + (vta_pkg::MacPW'(mul_p) <<< vta_pkg::MacHalfW);
          state_q <= M_DONE;
        end
        M_DONE: begin
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == M_DONE);
  assign prod_o = acc_q;

endmodule

// File: rtl/vta_rootdiv.sv
// shared iterative unit: floor square root one bit per cycle, or restoring
// division one quotient bit per cycle, on one compare/subtract; uses vta_pkg
module vta_rootdiv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  vta_pkg::rd_op_e                op_i,
  input  logic [vta_pkg::RdNumW-1:0]     num_i,
  input  logic [vta_pkg::RdDenW-1:0]     den_i,
  output logic                           done_o,
  output logic [vta_pkg::RdResW-1:0]     res_o
);

  typedef enum logic [1:0] {
    R_IDLE,
    R_RUN,
    R_DONE
  } rd_state_e;

  rd_state_e                      state_q;
  vta_pkg::rd_op_e                op_q;
  logic [vta_pkg::RdNumW-1:0]     acc_q;
  logic [vta_pkg::RdNumW-1:0]     aux_q;
  logic [vta_pkg::RdNumW-1:0]     bit_q;
  logic [vta_pkg::RdResW-1:0]     quo_q;
  logic [vta_pkg::RdCntW-1:0]     cnt_q;

  logic [vta_pkg::RdNumW-1:0] trial;
  logic [vta_pkg::RdNumW-1:0] diff;
  logic                       ge;

  always_comb begin
    trial = (op_q == vta_pkg::RD_ROOT) ? aux_q + bit_q : aux_q;
    ge    = (acc_q >= trial);
    diff  = acc_q - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      op_q    <= vta_pkg::RD_ROOT;
      acc_q   <= '0;
      aux_q   <= '0;
      bit_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            op_q  <= op_i;
            quo_q <= '0;
            bit_q <= vta_pkg::RdNumW'(1) << (vta_pkg::RdRootInW - 2);
            if (op_i == vta_pkg::RD_ROOT) begin
              acc_q <= vta_pkg::RdNumW'(num_i[vta_pkg::RdRootInW-1:0]);
              aux_q <= '0;
              cnt_q <= vta_pkg::RdCntW'(vta_pkg::RdResW);
            end else begin
              acc_q <= num_i;
              // divisor lined up with the top quotient bit
              aux_q <= vta_pkg::RdNumW'(den_i) << (vta_pkg::ForceW - 1);
              cnt_q <= vta_pkg::RdCntW'(vta_pkg::ForceW);
            end
            state_q <= R_RUN;
          end
        end
        R_RUN: begin
          if (ge) begin
            acc_q <= diff;
          end
          if (op_q == vta_pkg::RD_ROOT) begin
            aux_q <= ge ? (aux_q >> 1) + bit_q : aux_q >> 1;
            bit_q <= bit_q >> 2;
          end else begin
            aux_q <= aux_q >> 1;
            quo_q <= {quo_q[vta_pkg::RdResW-2:0], ge};
          end
          cnt_q <= cnt_q - vta_pkg::RdCntW'(1);
          if (cnt_q == vta_pkg::RdCntW'(1)) begin
            state_q <= R_DONE;
          end
        end
        R_DONE: begin
          state_q <= R_IDLE;
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == R_DONE);
  assign res_o  = (op_q == vta_pkg::RD_ROOT) ? aux_q[vta_pkg::RdResW-1:0] : quo_q;

endmodule

// File: rtl/smc_velocity_thrust_allocator_unit.sv
// sliding-mode surge/sway speed controller with four-thruster allocation
// sequencer around vta_mac and vta_rootdiv; uses vta_pkg
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  target/measured surge and sway
//   out      output     out_valid / out_stall four thruster forces
//   cfg      input      cfg_valid / cfg_ready register index, write data
//
// each request runs until its result is in the output register, and only then
// is the next request taken; the forces are divided per thruster only when
// they must be scaled down; the 28-step square root per axis and the 24-step
// divide per thruster in vta_rootdiv are the longest steps of the sequence
// in_stall is high from acceptance until the result is in the output register
// reset clears gains to their defaults and the error state to zero
module smc_velocity_thrust_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vta_pkg::SpeedW-1:0]   target_surge_i,
  input  logic signed [vta_pkg::SpeedW-1:0]   target_sway_i,
  input  logic signed [vta_pkg::SpeedW-1:0]   measured_surge_i,
  input  logic signed [vta_pkg::SpeedW-1:0]   measured_sway_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [vta_pkg::ForceW-1:0]   thrust_front_left_o,
  output logic        [vta_pkg::ForceW-1:0]   thrust_front_right_o,
  output logic        [vta_pkg::ForceW-1:0]   thrust_rear_left_o,
  output logic        [vta_pkg::ForceW-1:0]   thrust_rear_right_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [vta_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [vta_pkg::GainW-1:0]    cfg_data_i
);

  localparam int unsigned IntShift = 13;
  localparam int unsigned QShift   = 16;
  localparam int unsigned IncW     = vta_pkg::ErrW + 1 + vta_pkg::TickW - IntShift;
  localparam int unsigned LinW     = vta_pkg::SurfW + vta_pkg::GainW - QShift;
  localparam int unsigned SumSW    = vta_pkg::SurfW + 2;
  localparam int unsigned SumDW    = LinW + 1;
  localparam int unsigned ThrW     = $clog2(vta_pkg::NumThr);
  localparam logic [ThrW-1:0] LastThr = ThrW'(vta_pkg::NumThr - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_ERR_W,
    S_SURF,
    S_SURF_W,
    S_ROOT,
    S_ROOT_W,
    S_RGAIN_W,
    S_LIN_W,
    S_ALLOC,
    S_A_W,
    S_B_W,
    S_SPREAD,
    S_SCALE,
    S_SCALE_W,
    S_DIV_W
  } seq_state_e;

  // configuration
  logic [vta_pkg::GainW-1:0] root_gain_q [2];
  logic [vta_pkg::GainW-1:0] lin_gain_q  [2];
  logic [vta_pkg::GainW-1:0] weight_q    [2];
  logic [vta_pkg::GainW-1:0] max_thrust_q;
  logic [vta_pkg::TickW-1:0] tick_q;

  // controller state and working registers
  seq_state_e                         state_q;
  logic                               ax_q;
  logic signed [vta_pkg::ErrW-1:0]    e_q      [2];
  logic signed [vta_pkg::ErrW-1:0]    prev_q   [2];
  logic signed [vta_pkg::IntegW-1:0]  integ_q  [2];
  logic signed [vta_pkg::DriveW-1:0]  drive_q  [2];
  logic signed [vta_pkg::SurfW-1:0]   s_q;
  logic signed [vta_pkg::AllocW-1:0]  root_q;
  logic signed [vta_pkg::AllocW-1:0]  av_q;
  logic signed [vta_pkg::AllocW-1:0]  bv_q;
  logic        [vta_pkg::AllocW-1:0]  top_q;
  logic        [vta_pkg::AllocW-1:0]  pv_q     [vta_pkg::NumThr];
  logic        [ThrW-1:0]             thr_q;
  logic        [vta_pkg::ForceW-1:0]  res_q    [vta_pkg::NumThr];
  logic        [vta_pkg::ForceW-1:0]  out_q    [vta_pkg::NumThr];
  logic                               out_valid_q;

  // shared unit requests
  logic                               mac_start_q;
  logic signed [vta_pkg::MacAW-1:0]   mac_a_q;
  logic        [vta_pkg::MacBW-1:0]   mac_b_q;
  logic                               mac_done;
  logic signed [vta_pkg::MacPW-1:0]   mac_p;
  logic                               rd_start_q;
  vta_pkg::rd_op_e                    rd_op_q;
  logic        [vta_pkg::RdNumW-1:0]  rd_num_q;
  logic        [vta_pkg::RdDenW-1:0]  rd_den_q;
  logic                               rd_done;
  logic        [vta_pkg::RdResW-1:0]  rd_res;

  vta_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start_q),
    .a_i     (mac_a_q),
    .b_i     (mac_b_q),
    .done_o  (mac_done),
    .prod_o  (mac_p)
  );

  vta_rootdiv u_rootdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_start_q),
    .op_i    (rd_op_q),
    .num_i   (rd_num_q),
    .den_i   (rd_den_q),
    .done_o  (rd_done),
    .res_o   (rd_res)
  );

  // datapath around the shared units
  logic signed [vta_pkg::ErrW:0]      err_sum;
  logic signed [vta_pkg::MacPW-1:0]   p_sh13;
  logic signed [vta_pkg::MacPW-1:0]   p_sh16;
  logic signed [vta_pkg::IntegW:0]    integ_sum;
  logic signed [vta_pkg::IntegW-1:0]  integ_sat;
  logic signed [SumSW-1:0]            s_sum;
  logic signed [vta_pkg::SurfW-1:0]   s_sat;
  logic        [vta_pkg::SurfW:0]     s_mag;
  logic        [vta_pkg::DriveW-1:0]  root_mag;
  logic signed [SumDW-1:0]            d_sum;
  logic signed [vta_pkg::DriveW-1:0]  d_sat;
  logic signed [vta_pkg::AllocW-1:0]  t_plus;
  logic signed [vta_pkg::AllocW-1:0]  t_minus;
  logic        [vta_pkg::AllocW-1:0]  a_mag;
  logic        [vta_pkg::AllocW-1:0]  b_mag;
  logic        [vta_pkg::AllocW-1:0]  m_val;
  logic                               need_scale;
  logic                               load_out;

  always_comb begin
    err_sum   = (vta_pkg::ErrW+1)'(e_q[ax_q]) + (vta_pkg::ErrW+1)'(prev_q[ax_q]);
    p_sh13    = mac_p >>> IntShift;
    p_sh16    = mac_p >>> QShift;

    integ_sum = (vta_pkg::IntegW+1)'(integ_q[ax_q])
              + (vta_pkg::IntegW+1)'($signed(p_sh13[IncW-1:0]));
    if (integ_sum[vta_pkg::IntegW] != integ_sum[vta_pkg::IntegW-1]) begin
      integ_sat = {integ_sum[vta_pkg::IntegW], {(vta_pkg::IntegW-1){~integ_sum[vta_pkg::IntegW]}}};
    end else begin
      integ_sat = integ_sum[vta_pkg::IntegW-1:0];
    end

    // surface: 16*e plus weighted integral
    s_sum = SumSW'($signed(p_sh16[vta_pkg::SurfW-1:0]))
          + SumSW'($signed({e_q[ax_q], 4'b0000}));
    if ((&s_sum[SumSW-1:vta_pkg::SurfW-1]) || !(|s_sum[SumSW-1:vta_pkg::SurfW-1])) begin
      s_sat = s_sum[vta_pkg::SurfW-1:0];
    end else begin
      s_sat = {s_sum[SumSW-1], {(vta_pkg::SurfW-1){~s_sum[SumSW-1]}}};
    end
    s_mag = s_q[vta_pkg::SurfW-1] ? -(vta_pkg::SurfW+1)'(s_q) : (vta_pkg::SurfW+1)'(s_q);

    root_mag = mac_p[QShift +: vta_pkg::DriveW];

    d_sum = SumDW'($signed(p_sh16[LinW-1:0])) + SumDW'(root_q);
    if ((&d_sum[SumDW-1:vta_pkg::DriveW-1]) || !(|d_sum[SumDW-1:vta_pkg::DriveW-1])) begin
      d_sat = d_sum[vta_pkg::DriveW-1:0];
    end else begin
      d_sat = {d_sum[SumDW-1], {(vta_pkg::DriveW-1){~d_sum[SumDW-1]}}};
    end

    t_plus  = vta_pkg::AllocW'(drive_q[0]) + vta_pkg::AllocW'(drive_q[1]);
    t_minus = vta_pkg::AllocW'(drive_q[0]) - vta_pkg::AllocW'(drive_q[1]);

    a_mag = av_q[vta_pkg::AllocW-1] ? vta_pkg::AllocW'(-av_q) : vta_pkg::AllocW'(av_q);
    b_mag = bv_q[vta_pkg::AllocW-1] ? vta_pkg::AllocW'(-bv_q) : vta_pkg::AllocW'(bv_q);
    m_val = (a_mag > b_mag) ? a_mag : b_mag;

    need_scale = (top_q > vta_pkg::AllocW'(max_thrust_q));
  end

  // all thrusters done and the output register free
  assign load_out = (state_q == S_DIV_W) && (thr_q == LastThr) && !need_scale
                 && (!out_valid_q || !out_stall_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_gain_q[0] <= vta_pkg::RootGainRst;
      root_gain_q[1] <= vta_pkg::RootGainRst;
      lin_gain_q[0]  <= vta_pkg::LinGainRst;
      lin_gain_q[1]  <= vta_pkg::LinGainRst;
      weight_q[0]    <= vta_pkg::WeightRst;
      weight_q[1]    <= vta_pkg::WeightRst;
      max_thrust_q   <= vta_pkg::MaxThrustRst;
      tick_q         <= vta_pkg::TickRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vta_pkg::CfgSurgeRoot:   root_gain_q[0] <= cfg_data_i;
        vta_pkg::CfgSurgeLinear: lin_gain_q[0]  <= cfg_data_i;
        vta_pkg::CfgSurgeWeight: weight_q[0]    <= cfg_data_i;
        vta_pkg::CfgSwayRoot:    root_gain_q[1] <= cfg_data_i;
        vta_pkg::CfgSwayLinear:  lin_gain_q[1]  <= cfg_data_i;
        vta_pkg::CfgSwayWeight:  weight_q[1]    <= cfg_data_i;
        vta_pkg::CfgMaxThrust:   max_thrust_q   <= cfg_data_i;
        vta_pkg::CfgTickPeriod:  tick_q         <= cfg_data_i[vta_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= 1'b0;
      thr_q       <= '0;
      out_valid_q <= 1'b0;
      mac_start_q <= 1'b0;
      mac_a_q     <= '0;
      mac_b_q     <= '0;
      rd_start_q  <= 1'b0;
      rd_op_q     <= vta_pkg::RD_ROOT;
      rd_num_q    <= '0;
      rd_den_q    <= '0;
      s_q         <= '0;
      root_q      <= '0;
      av_q        <= '0;
      bv_q        <= '0;
      top_q       <= '0;
      for (int i = 0; i < 2; i++) begin
        e_q[i]     <= '0;
        prev_q[i]  <= '0;
        integ_q[i] <= '0;
        drive_q[i] <= '0;
      end
      for (int i = 0; i < vta_pkg::NumThr; i++) begin
        pv_q[i]  <= '0;
        res_q[i] <= '0;
        out_q[i] <= '0;
      end
    end else begin
      mac_start_q <= 1'b0;
      rd_start_q  <= 1'b0;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            e_q[0]  <= vta_pkg::ErrW'(target_surge_i) - vta_pkg::ErrW'(measured_surge_i);
            e_q[1]  <= vta_pkg::ErrW'(target_sway_i) - vta_pkg::ErrW'(measured_sway_i);
            ax_q    <= 1'b0;
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          mac_a_q     <= vta_pkg::MacAW'(err_sum);
          mac_b_q     <= vta_pkg::MacBW'(tick_q);
          mac_start_q <= 1'b1;
          state_q     <= S_ERR_W;
        end
        S_ERR_W: begin
          if (mac_done) begin
            integ_q[ax_q] <= integ_sat;
            prev_q[ax_q]  <= e_q[ax_q];
            state_q       <= S_SURF;
          end
        end
        S_SURF: begin
          mac_a_q     <= vta_pkg::MacAW'(integ_q[ax_q]);
          mac_b_q     <= weight_q[ax_q];
          mac_start_q <= 1'b1;
          state_q     <= S_SURF_W;
        end
        S_SURF_W: begin
          if (mac_done) begin
            s_q     <= s_sat;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          rd_op_q    <= vta_pkg::RD_ROOT;
          rd_num_q   <= vta_pkg::RdNumW'({s_mag[vta_pkg::SurfW-1:0], 16'h0000});
          rd_start_q <= 1'b1;
          state_q    <= S_ROOT_W;
        end
        S_ROOT_W: begin
          if (rd_done) begin
            mac_a_q     <= vta_pkg::MacAW'(rd_res);
            mac_b_q     <= root_gain_q[ax_q];
            mac_start_q <= 1'b1;
            state_q     <= S_RGAIN_W;
          end
        end
        S_RGAIN_W: begin
          if (mac_done) begin
            // root term takes the sign of the surface
            if (s_q[vta_pkg::SurfW-1]) begin
              root_q <= -$signed({1'b0, root_mag});
            end else begin
              root_q <= $signed({1'b0, root_mag});
            end
            mac_a_q     <= vta_pkg::MacAW'(s_q);
            mac_b_q     <= lin_gain_q[ax_q];
            mac_start_q <= 1'b1;
            state_q     <= S_LIN_W;
          end
        end
        S_LIN_W: begin
          if (mac_done) begin
            drive_q[ax_q] <= d_sat;
            if (!ax_q) begin
              ax_q    <= 1'b1;
              state_q <= S_ERR;
            end else begin
              state_q <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          mac_a_q     <= vta_pkg::MacAW'(t_plus);
          mac_b_q     <= vta_pkg::AllocK;
          mac_start_q <= 1'b1;
          state_q     <= S_A_W;
        end
        S_A_W: begin
          if (mac_done) begin
            av_q        <= p_sh16[vta_pkg::AllocW-1:0];
            mac_a_q     <= vta_pkg::MacAW'(t_minus);
            mac_b_q     <= vta_pkg::AllocK;
            mac_start_q <= 1'b1;
            state_q     <= S_B_W;
          end
        end
        S_B_W: begin
          if (mac_done) begin
            bv_q    <= p_sh16[vta_pkg::AllocW-1:0];
            state_q <= S_SPREAD;
          end
        end
        S_SPREAD: begin
          // shift so the smallest force is zero
          top_q   <= m_val << 1;
          pv_q[0] <= m_val + av_q;
          pv_q[1] <= m_val + bv_q;
          pv_q[2] <= m_val - bv_q;
          pv_q[3] <= m_val - av_q;
          thr_q   <= '0;
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          if (need_scale) begin
            mac_a_q     <= vta_pkg::MacAW'(pv_q[thr_q]);
            mac_b_q     <= max_thrust_q;
            mac_start_q <= 1'b1;
            state_q     <= S_SCALE_W;
          end else begin
            res_q[thr_q] <= (pv_q[thr_q] > vta_pkg::AllocW'(max_thrust_q))
                          ? max_thrust_q : pv_q[thr_q][vta_pkg::ForceW-1:0];
            if (thr_q == LastThr) begin
              state_q <= S_DIV_W;
            end else begin
              thr_q   <= thr_q + ThrW'(1);
              state_q <= S_SCALE;
            end
          end
        end
        S_SCALE_W: begin
          if (mac_done) begin
            rd_op_q    <= vta_pkg::RD_DIV;
            rd_num_q   <= mac_p[vta_pkg::RdNumW-1:0];
            rd_den_q   <= top_q;
            rd_start_q <= 1'b1;
            state_q    <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          // also the output stage once the last thruster is done
          if (thr_q == LastThr && !need_scale) begin
            if (load_out) begin
              for (int i = 0; i < vta_pkg::NumThr; i++) begin
                out_q[i] <= res_q[i];
              end
              state_q <= S_IDLE;
            end
          end else if (rd_done) begin
            res_q[thr_q] <= (rd_res > vta_pkg::RdResW'(max_thrust_q))
                          ? max_thrust_q : rd_res[vta_pkg::ForceW-1:0];
            if (thr_q == LastThr) begin
              top_q <= '0;
            end else begin
              thr_q   <= thr_q + ThrW'(1);
              state_q <= S_SCALE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign thrust_front_left_o  = out_q[0];
  assign thrust_front_right_o = out_q[1];
  assign thrust_rear_left_o   = out_q[2];
  assign thrust_rear_right_o  = out_q[3];

endmodule
